FILE: sv/cpbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbp_pkg
// Shared types and constants for the CAN payload bit packer.
// ----------------------------------------------------------------------------
package cpbp_pkg;

   // field widths
   localparam int ID_W      = 29;
   localparam int BITS_W    = 7;
   localparam int PAY_W     = 64;
   localparam int STATUS_W  = 3;
   localparam int FILL_W    = 7;
   localparam int ENTRY_W   = FILL_W + PAY_W;

   // default table depth
   localparam int DEF_MAX_FRAMES = 8;

   // operation codes
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_SEND  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_ZERO     = 3'd1,
      ST_OVERFLOW = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_SENT     = 3'd5
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_ACCESS
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic req_load;
      logic search;
      logic commit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic in_nop;
   } sts_type;

endpackage

FILE: sv/cpbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpbp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/cpbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbp_ctrl
// Sequencer for the bit packer: capture, table search, commit to result.
// ----------------------------------------------------------------------------
module cpbp_ctrl
   import cpbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register can take a new beat
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               if (!sts.in_nop) begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = S_ACCESS;
         end
         S_ACCESS: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/cpbp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbp_datapath
// Frame table, identifier match, field packing and result register.
// ----------------------------------------------------------------------------
module cpbp_datapath
   import cpbp_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [1:0]          req_op,
   input  logic [ID_W-1:0]     req_frame_id,
   input  logic [BITS_W-1:0]   req_field_bits,
   input  logic [PAY_W-1:0]    req_field_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_out_id,
   output logic [PAY_W-1:0]    rsp_out_payload,
   output logic [FILL_W-1:0]   rsp_bits_used
);

   localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   // captured request
   op_type              op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [BITS_W-1:0]   bits_ff;
   logic [PAY_W-1:0]    value_ff;

   // identifier store, one comparator per entry
   logic [MAX_FRAMES-1:0] valid_ff;
   logic [ID_W-1:0]       tag_ff [MAX_FRAMES];

   // search result
   logic                hit_ff, room_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [MAX_FRAMES-1:0] match;
   logic                hit, room;
   logic [SLOT_W-1:0]   hit_idx, free_idx, slot_sel;

   // commit signals
   logic [ENTRY_W-1:0]  rd_entry, wr_entry;
   logic [FILL_W-1:0]   old_fill, new_fill;
   logic [PAY_W-1:0]    old_pay, new_pay, mask, shifted;
   logic [FILL_W:0]     sum;
   logic                over, field_op, placed, alloc, wr_en;
   status_type          status;
   logic [FILL_W-1:0]   out_fill;
   logic [PAY_W-1:0]    out_pay;

   // result register
   logic [STATUS_W-1:0] status_ff;
   logic [ID_W-1:0]     out_id_ff;
   logic [PAY_W-1:0]    out_pay_ff;
   logic [FILL_W-1:0]   out_fill_ff;

   assign sts.in_nop = (op_type'(req_op) == OP_NOP);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff    <= op_type'(req_op);
         id_ff    <= req_frame_id;
         bits_ff  <= req_field_bits;
         value_ff <= req_field_value;
      end
   end

   // parallel identifier match, lowest match and lowest free slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (tag_ff[i] == id_ff);
         if (match[i]) begin
            hit_idx = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
      hit      = |match;
      room     = !(&valid_ff);
      slot_sel = hit ? hit_idx : free_idx;
   end

   // search result register
   always_ff @(posedge clock) begin
      if (cmd.search) begin
         hit_ff  <= hit;
         room_ff <= room;
         slot_ff <= slot_sel;
      end
   end

   // payload and fill storage
   cpbp_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (MAX_FRAMES),
      .ADDR_W (SLOT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.search),
      .rd_addr (slot_sel),
      .rd_data (rd_entry)
   );

   // field packing and result selection
   always_comb begin
      old_fill = hit_ff ? rd_entry[ENTRY_W-1:PAY_W] : '0;
      old_pay  = hit_ff ? rd_entry[PAY_W-1:0] : '0;
      sum      = {1'b0, old_fill} + {1'b0, bits_ff};
      over     = sum > (FILL_W + 1)'(PAY_W);
      mask     = bits_ff[BITS_W-1] ? '1 : ((PAY_W'(1) << bits_ff[BITS_W-2:0]) - PAY_W'(1));
      shifted  = (value_ff & mask) << old_fill[FILL_W-2:0];
      field_op = (op_ff == OP_CLEAR) || ((op_ff == OP_ADD) && (bits_ff != '0));
      placed   = hit_ff || room_ff;
      alloc    = field_op && !hit_ff && room_ff;
      new_fill = old_fill;
      new_pay  = old_pay;
      out_fill = old_fill;
      out_pay  = old_pay;
      status   = ST_OK;
      unique case (op_ff)
         OP_ADD: begin
            if (bits_ff == '0) begin
               status = ST_ZERO;
            end else if (!placed) begin
               status = ST_FULL;
            end else if (over) begin
               status = ST_OVERFLOW;
            end else begin
               new_fill = sum[FILL_W-1:0];
               new_pay  = old_pay | shifted;
               out_fill = new_fill;
               out_pay  = new_pay;
            end
         end
         OP_CLEAR: begin
            new_fill = '0;
            new_pay  = '0;
            out_fill = '0;
            out_pay  = '0;
            status   = placed ? ST_OK : ST_FULL;
         end
         OP_SEND: begin
            status = hit_ff ? ST_SENT : ST_NOTFOUND;
         end
         default: begin
            status = ST_OK;
         end
      endcase
      wr_en    = cmd.commit && field_op && placed;
      wr_entry = {new_fill, new_pay};
   end

   // identifier store, valid bits cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && alloc) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && alloc) begin
         tag_ff[slot_ff] <= id_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff   <= status;
         out_id_ff   <= id_ff;
         out_pay_ff  <= out_pay;
         out_fill_ff <= out_fill;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_out_id      = out_id_ff;
   assign rsp_out_payload = out_pay_ff;
   assign rsp_bits_used   = out_fill_ff;

endmodule

FILE: sv/can_payload_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_payload_bit_packer
// Table of CAN frames keyed by identifier; packs fields into 64-bit payloads.
// ----------------------------------------------------------------------------
// Each request beat runs through capture, a search that compares the
// identifier against every table entry in parallel while the RAM read of
// the matching (or lowest free) slot is issued, and a commit that uses the
// registered read of the payload RAM to update the entry and load the
// result register. An op code of 3 is dropped at capture with no result.
// A result waiting in the output register holds the commit back, and the
// request side stays stalled until that commit is done. The table holds
// MAX_FRAMES entries that only reset removes; status 3 reports a full
// table.
// ----------------------------------------------------------------------------
module can_payload_bit_packer
   import cpbp_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [ID_W-1:0]     req_frame_id,
   input  logic [BITS_W-1:0]   req_field_bits,
   input  logic [PAY_W-1:0]    req_field_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_out_id,
   output logic [PAY_W-1:0]    rsp_out_payload,
   output logic [FILL_W-1:0]   rsp_bits_used
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   cpbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table and packing datapath
   cpbp_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_op),
      .req_frame_id    (req_frame_id),
      .req_field_bits  (req_field_bits),
      .req_field_value (req_field_value),
      .rsp_status      (rsp_status),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_payload (rsp_out_payload),
      .rsp_bits_used   (rsp_bits_used)
   );

endmodule

FILE: sv/cpbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbp_checker
// Port-level assertions for the CAN payload bit packer.
// ----------------------------------------------------------------------------
module cpbp_checker
   import cpbp_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [1:0]          req_op,
   input logic [ID_W-1:0]     req_frame_id,
   input logic [BITS_W-1:0]   req_field_bits,
   input logic [PAY_W-1:0]    req_field_value,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ID_W-1:0]     rsp_out_id,
   input logic [PAY_W-1:0]    rsp_out_payload,
   input logic [FILL_W-1:0]   rsp_bits_used
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_id) && $stable(rsp_out_payload) && $stable(rsp_bits_used))
      else $error("result beat changed while stalled");

   // a real operation keeps the block busy the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op != OP_NOP) |=> req_stall)
      else $error("request taken while previous one still searching");

   // only defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_SENT))
      else $error("undefined status code");

   // full table and missing frame report an empty frame
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_FULL) || (rsp_status == ST_NOTFOUND))
         |-> (rsp_out_payload == '0) && (rsp_bits_used == '0))
      else $error("full or not-found result carries data");

   // fill level never passes 64 bits
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bits_used[FILL_W-1] |-> (rsp_bits_used[FILL_W-2:0] == '0))
      else $error("fill level beyond 64");

endmodule

bind can_payload_bit_packer cpbp_checker u_cpbp_checker (.*);

FILE: tb/cpbp_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbp_frame_checker
// Watches the request and result channels of the CAN payload bit packer.
// Each accepted request beat runs through a private copy of the frame table,
// and the predicted result is queued. Each accepted result beat is compared,
// field by field, with the oldest queued prediction.
// ----------------------------------------------------------------------------
module cpbp_frame_checker
   import cpbp_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [ID_W-1:0]     req_frame_id,
   input  logic [BITS_W-1:0]   req_field_bits,
   input  logic [PAY_W-1:0]    req_field_value,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [ID_W-1:0]     rsp_out_id,
   input  logic [PAY_W-1:0]    rsp_out_payload,
   input  logic [FILL_W-1:0]   rsp_bits_used,
   output int                  results_owed,
   output int                  fault_count
);

   typedef struct {
      status_type        status;
      logic [ID_W-1:0]   frame_id;
      logic [PAY_W-1:0]  payload;
      logic [FILL_W-1:0] fill;
   } frame_result_type;

   // private copy of the frame table
   bit                slot_live [MAX_FRAMES];
   logic [ID_W-1:0]   slot_id   [MAX_FRAMES];
   logic [FILL_W-1:0] slot_fill [MAX_FRAMES];
   logic [PAY_W-1:0]  slot_data [MAX_FRAMES];

   frame_result_type owed_q[$];
   frame_result_type predicted;
   frame_result_type oldest;
   int               faults = 0;
   int               rsp_beats = 0;

   // slot holding this identifier, or -1
   function automatic int find_slot(input logic [ID_W-1:0] id);
      for (int i = 0; i < MAX_FRAMES; i++)
         if (slot_live[i] && slot_id[i] == id)
            return i;
      return -1;
   endfunction

   // existing slot, else the lowest free one (emptied), else -1 when full
   function automatic int claim_slot(input logic [ID_W-1:0] id);
      int s;
      s = find_slot(id);
      if (s >= 0)
         return s;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (!slot_live[i]) begin
            slot_live[i] = 1'b1;
            slot_id[i]   = id;
            slot_fill[i] = '0;
            slot_data[i] = '0;
            return i;
         end
      end
      return -1;
   endfunction

   // apply one request to the table; returns 0 when no result is due
   function automatic bit pack_frame(input logic [1:0] op,
                                     input logic [ID_W-1:0] id,
                                     input logic [BITS_W-1:0] nbits,
                                     input logic [PAY_W-1:0] value,
                                     output frame_result_type res);
      int               slot;
      logic [PAY_W-1:0] mask;
      slot         = -1;
      res.status   = ST_OK;
      res.frame_id = id;
      res.payload  = '0;
      res.fill     = '0;
      case (op_type'(op))
         OP_ADD: begin
            if (nbits == 0) begin
               // zero-length field never allocates
               res.status = ST_ZERO;
               slot = find_slot(id);
            end else begin
               slot = claim_slot(id);
               if (slot < 0) begin
                  res.status = ST_FULL;
               end else if (int'(slot_fill[slot]) + int'(nbits) > PAY_W) begin
                  res.status = ST_OVERFLOW;
               end else begin
                  mask = (nbits >= PAY_W) ? '1 : ((64'd1 << nbits) - 64'd1);
                  slot_data[slot] |= (value & mask) << slot_fill[slot];
                  slot_fill[slot] += nbits;
               end
            end
         end
         OP_CLEAR: begin
            slot = claim_slot(id);
            if (slot < 0) begin
               res.status = ST_FULL;
            end else begin
               slot_fill[slot] = '0;
               slot_data[slot] = '0;
            end
         end
         OP_SEND: begin
            slot = find_slot(id);
            res.status = (slot < 0) ? ST_NOTFOUND : ST_SENT;
         end
         default: return 1'b0;
      endcase
      if (slot >= 0) begin
         res.payload = slot_data[slot];
         res.fill    = slot_fill[slot];
      end
      return 1'b1;
   endfunction

   // predict on request beats, compare on result beats
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FRAMES; i++)
            slot_live[i] = 1'b0;
         owed_q.delete();
      end else begin
         if (req_valid && !req_stall)
            if (pack_frame(req_op, req_frame_id, req_field_bits, req_field_value,
                           predicted))
               owed_q.insert(owed_q.size(), predicted);
         if (rsp_valid && !rsp_stall) begin
            rsp_beats++;
            if (owed_q.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("result beat %0d: nothing pending, status %0d id %h",
                           rsp_beats, rsp_status, rsp_out_id);
            end else begin
               oldest = owed_q.pop_front();
               if (rsp_status !== oldest.status || rsp_out_id !== oldest.frame_id ||
                   rsp_out_payload !== oldest.payload ||
                   rsp_bits_used !== oldest.fill) begin
                  faults++;
                  if (faults <= 10) begin
                     $display("result beat %0d: exp status %0d id %h payload %h fill %0d",
                              rsp_beats, oldest.status, oldest.frame_id,
                              oldest.payload, oldest.fill);
                     $display("result beat %0d: got status %0d id %h payload %h fill %0d",
                              rsp_beats, rsp_status, rsp_out_id,
                              rsp_out_payload, rsp_bits_used);
                  end
               end
            end
         end
      end
      results_owed <= owed_q.size();
      fault_count  <= faults;
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the CAN payload bit packer. A directed run covers
// allocation, zero-length adds, overflow, full table and missing frames; a
// random run then works mostly on a pool of resident frames with random
// fields, plus fresh identifiers and dropped op codes. Both sides idle in
// random bursts. Checking is done by cpbp_frame_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import cpbp_pkg::*;

   localparam int RANDOM_BEATS = 530;
   localparam int TAIL_BEATS   = 60;
   localparam int PAUSE_AT     = 260;
   localparam int DRAIN_CYCLES = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_op = '0;
   logic [ID_W-1:0]     req_frame_id = '0;
   logic [BITS_W-1:0]   req_field_bits = '0;
   logic [PAY_W-1:0]    req_field_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_out_id;
   logic [PAY_W-1:0]    rsp_out_payload;
   logic [FILL_W-1:0]   rsp_bits_used;

   int results_owed;
   int fault_count;
   bit tail_run = 1'b0;
   int stall_left = 0;
   int stall_calm = 0;
   int gap_calm = 0;

   // frames that stay resident once the directed run has filled the table
   logic [ID_W-1:0] pool_ids [8] = '{29'h1FFF_FFFF, 29'h000_0001, 29'h1555_5555,
                                     29'h0AAA_AAAA, 29'h1234_5678, 29'h000_0100,
                                     29'h1F00_00F0, 29'h0F0F_0F0F};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   can_payload_bit_packer #(
      .MAX_FRAMES (DEF_MAX_FRAMES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_frame_id    (req_frame_id),
      .req_field_bits  (req_field_bits),
      .req_field_value (req_field_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_payload (rsp_out_payload),
      .rsp_bits_used   (rsp_bits_used)
   );

   cpbp_frame_checker #(
      .MAX_FRAMES (DEF_MAX_FRAMES)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_frame_id    (req_frame_id),
      .req_field_bits  (req_field_bits),
      .req_field_value (req_field_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_payload (rsp_out_payload),
      .rsp_bits_used   (rsp_bits_used),
      .results_owed    (results_owed),
      .fault_count     (fault_count)
   );

   // result-side stall bursts with calm stretches between them
   always @(posedge clock) begin
      if (reset || tail_run) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0 && stall_calm == 0) begin
            case ($urandom_range(0, 9))
               0:       stall_calm = $urandom_range(20, 60);
               1, 2, 3: stall_left = $urandom_range(1, 7);
               default: ;
            endcase
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_calm != 0)
               stall_calm--;
         end
      end
   end

   // one request beat, with an optional gap ahead of it
   task automatic push_beat(input op_type op, input logic [ID_W-1:0] id,
                            input logic [BITS_W-1:0] nbits,
                            input logic [PAY_W-1:0] value);
      int r;
      r = $urandom_range(0, 9);
      if (!tail_run) begin
         if (gap_calm != 0) begin
            gap_calm--;
         end else if (r == 0) begin
            gap_calm = $urandom_range(8, 30);
         end else if (r < 4) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_frame_id    <= id;
      req_field_bits  <= nbits;
      req_field_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // mostly resident frames, some fresh identifiers and dropped op codes
   task automatic push_random_beat();
      op_type            op;
      logic [ID_W-1:0]   id;
      logic [BITS_W-1:0] nbits;
      logic [PAY_W-1:0]  value;
      int                r;
      r = $urandom_range(0, 99);
      if (r < 72)
         id = pool_ids[$urandom_range(0, 7)];
      else
         id = ID_W'($urandom);
      r = $urandom_range(0, 99);
      op = (r < 60) ? OP_ADD : (r < 75) ? OP_CLEAR : (r < 95) ? OP_SEND : OP_NOP;
      r = $urandom_range(0, 99);
      if (r < 8)
         nbits = '0;
      else if (r < 70)
         nbits = BITS_W'($urandom_range(1, 12));
      else if (r < 90)
         nbits = BITS_W'($urandom_range(13, 32));
      else if (r < 97)
         nbits = BITS_W'($urandom_range(33, 64));
      else
         nbits = BITS_W'($urandom_range(65, 127));
      value = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0)
         value = '1;
      push_beat(op, id, nbits, value);
   endtask

   // hold the sender off until every pending result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // missing frame: send and zero-length add leave the table empty
      push_beat(OP_SEND, '0, '0, '0);
      push_beat(OP_ADD, '0, '0, '1);
      push_beat(OP_SEND, '0, '0, '0);
      // full 64-bit field, then overflow by one bit
      push_beat(OP_ADD, pool_ids[0], 7'd64, '1);
      push_beat(OP_ADD, pool_ids[0], 7'd1, '1);
      push_beat(OP_ADD, pool_ids[0], '0, '1);
      push_beat(OP_SEND, pool_ids[0], '0, '0);
      push_beat(OP_CLEAR, pool_ids[0], '0, '1);
      // oversize field allocates an empty frame
      push_beat(OP_ADD, pool_ids[1], 7'd127, '1);
      push_beat(OP_ADD, pool_ids[1], 7'd65, '1);
      push_beat(OP_SEND, pool_ids[1], '0, '0);
      push_beat(OP_NOP, pool_ids[2], 7'd8, '1);
      push_beat(OP_CLEAR, pool_ids[2], '0, '0);
      // append above existing bits and mask the upper value bits
      push_beat(OP_ADD, pool_ids[3], 7'd1, '1);
      push_beat(OP_ADD, pool_ids[3], 7'd63, 64'hAAAA_AAAA_AAAA_AAAA);
      push_beat(OP_CLEAR, pool_ids[4], '0, '0);
      push_beat(OP_CLEAR, pool_ids[5], '0, '0);
      push_beat(OP_ADD, pool_ids[6], 7'd8, 64'hFFFF_0000_0000_1234);
      push_beat(OP_CLEAR, pool_ids[7], '0, '0);
      // table now full
      push_beat(OP_ADD, 29'h1FFF_FFFE, 7'd4, '1);
      push_beat(OP_CLEAR, '0, '0, '0);
      push_beat(OP_SEND, 29'h1FFF_FFFE, '0, '0);
      push_beat(OP_ADD, '0, '0, '0);
      push_beat(OP_ADD, pool_ids[6], 7'd56, '1);
      push_beat(OP_NOP, '0, '0, '0);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == RANDOM_BEATS - TAIL_BEATS)
            tail_run <= 1'b1;
         if (n == PAUSE_AT)
            wait_drained();
         push_random_beat();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && results_owed == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hang guard
   initial begin
      #1_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
